[design/led_matrix_row_scanner_defines.svh]
// Assertion macros for the checker file of the row scanner.
`ifndef LED_MATRIX_ROW_SCANNER_DEFINES_SVH
`define LED_MATRIX_ROW_SCANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define LMS_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[design/lms_pkg.sv]
// Types, constants and helpers for the LED matrix row scanner.
package lms_pkg;

    // Matrix geometry
    localparam int MATRIX_COLUMNS = 16;
    localparam int MATRIX_ROWS    = 16;
    localparam int COL_W          = $clog2(MATRIX_COLUMNS);
    localparam int ROW_W          = $clog2(MATRIX_ROWS);
    localparam int STORE_DEPTH    = MATRIX_COLUMNS * MATRIX_ROWS;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);

    // Fixed field widths of the ports
    localparam int FIELD_W = 4;
    localparam int COLOR_W = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input mode codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [FIELD_W-1:0] column_x;
        logic [FIELD_W-1:0] row_y;
        logic [COLOR_W-1:0] pixel_color;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] row_address;
        logic [FIELD_W-1:0] column_index;
        logic               red_bit;
        logic               green_data;
        logic               last_of_row;
    } t_out;

    typedef enum logic {
        CMD_WRITE,
        CMD_TICK
    } t_cmd_kind;

    // Classified request handed from front to back
    typedef struct packed {
        t_cmd_kind          kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    typedef enum logic {
        SCAN_IDLE,
        SCAN_RUN
    } t_scan_state;

    // Frame store address of one pixel
    function automatic logic [ADDR_W-1:0] lms_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        lms_addr = ADDR_W'(row * MATRIX_COLUMNS + col);
    endfunction

endpackage

[design/led_matrix_row_scanner.sv]
// Top level of the LED matrix row scanner.
//
// Input channel (i_in_valid / o_in_stall / i_in) takes requests: mode 0
// writes one 2-bit pixel colour into the 16x16 frame store, mode 1 is a
// scan tick for one row. Writes outside the matrix are dropped.
// Output channel (o_out_valid / i_out_stall / o_out) gives 16 results per
// tick, one per column: the driven row address, the column index, the red
// and green bits taken from the next row (wrapping), and last_of_row on
// the final column. The row counter advances after each tick.
// A request passes a front register and a two-entry command queue; the
// engine then reads the frame store into a read register and passes the
// result to the output register. A write occupies the scan engine only
// for its command pop; a tick for 16 frame store reads, one per cycle
// while the output does not stall, plus the command pop; no new command
// is taken meanwhile. The single frame store read port sets this limit.
// Reset clears the row counter, the front register, the command queue and
// the pixel written flags, so the whole frame reads as no colour. When the
// receiver stalls, the output holds and the engine stops once its read
// register is full; the queue then fills and the input stalls.
module led_matrix_row_scanner (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lms_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lms_pkg::t_out o_out
);

    logic          front_valid;
    lms_pkg::t_cmd front_cmd;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    lms_pkg::t_cmd q_cmd;

    lms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (front_valid),
        .i_cmd_full  (q_full),
        .o_cmd       (front_cmd)
    );

    lms_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    lms_scan_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

[design/lms_front.sv]
// Front stage: accepts requests, drops off-matrix writes, builds commands.
module lms_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lms_pkg::t_in  i_in,
    output logic          o_cmd_valid,
    input  logic          i_cmd_full,
    output lms_pkg::t_cmd o_cmd
);

    logic          r_valid;
    lms_pkg::t_cmd r_cmd;
    lms_pkg::t_cmd n_cmd;
    logic          accept;
    logic          keep;
    logic          push;

    assign push       = r_valid && !i_cmd_full;
    assign o_in_stall = r_valid && i_cmd_full;
    assign accept     = i_in_valid && !o_in_stall;

    // Classify: ticks always pass, writes only inside the matrix
    always_comb begin
        n_cmd.kind  = (i_in.mode == lms_pkg::MODE_TICK) ? lms_pkg::CMD_TICK
                                                        : lms_pkg::CMD_WRITE;
        n_cmd.row   = lms_pkg::ROW_W'(i_in.row_y);
        n_cmd.col   = lms_pkg::COL_W'(i_in.column_x);
        n_cmd.color = i_in.pixel_color;
        keep = (i_in.mode == lms_pkg::MODE_TICK) ||
               ((int'(i_in.column_x) < lms_pkg::MATRIX_COLUMNS) &&
                (int'(i_in.row_y) < lms_pkg::MATRIX_ROWS));
    end

    // Holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

[design/lms_cmd_queue.sv]
// Short command queue between the front and the scan engine.
module lms_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lms_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output lms_pkg::t_cmd o_cmd
);

    lms_pkg::t_cmd                r_entry [lms_pkg::QUEUE_DEPTH];
    logic [lms_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [lms_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [lms_pkg::QCNT_W-1:0]   r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == lms_pkg::QCNT_W'(lms_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_entry[r_rd_ptr];

    // Pointer and fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == lms_pkg::QPTR_W'(lms_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == lms_pkg::QPTR_W'(lms_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/lms_scan_engine.sv]
// Back end: frame store, row counter and the per-column shift sequencer.
module lms_scan_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  lms_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lms_pkg::t_out o_out
);

    // Frame store and its written flags
    logic [lms_pkg::COLOR_W-1:0] mem [lms_pkg::STORE_DEPTH];
    logic [lms_pkg::STORE_DEPTH-1:0] r_vld;

    lms_pkg::t_scan_state r_state;
    lms_pkg::t_scan_state n_state;

    logic [lms_pkg::ROW_W-1:0] r_row;
    logic [lms_pkg::ROW_W-1:0] row_next;
    logic [lms_pkg::COL_W-1:0] r_col;
    logic                      col_last;

    // Read stage
    logic                        r_rd_v;
    logic [lms_pkg::ROW_W-1:0]   r_rd_row;
    logic [lms_pkg::COL_W-1:0]   r_rd_col;
    logic                        r_rd_last;
    logic [lms_pkg::COLOR_W-1:0] r_rd_color;
    logic                        r_rd_hit;

    // Output stage
    logic          r_out_v;
    lms_pkg::t_out r_out;

    logic                        move;
    logic                        rd_free;
    logic                        rd_en;
    logic                        mem_we;
    logic [lms_pkg::ADDR_W-1:0]  waddr;
    logic [lms_pkg::ADDR_W-1:0]  raddr;
    logic [lms_pkg::COLOR_W-1:0] color;

    assign row_next = (r_row == lms_pkg::ROW_W'(lms_pkg::MATRIX_ROWS - 1))
                      ? '0 : r_row + 1'b1;
    assign col_last = (r_col == lms_pkg::COL_W'(lms_pkg::MATRIX_COLUMNS - 1));
    assign move     = r_rd_v && (!r_out_v || !i_out_stall);
    assign rd_free  = !r_rd_v || move;
    assign waddr    = lms_pkg::lms_addr(i_cmd.row, i_cmd.col);
    // Data come from the row after the one being driven
    assign raddr    = lms_pkg::lms_addr(row_next, r_col);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lms_pkg::SCAN_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == lms_pkg::CMD_TICK) begin
                    n_state = lms_pkg::SCAN_RUN;
                end
            end
            lms_pkg::SCAN_RUN: begin
                if (rd_free && col_last) begin
                    n_state = lms_pkg::SCAN_IDLE;
                end
            end
            default: n_state = lms_pkg::SCAN_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        unique case (r_state)
            lms_pkg::SCAN_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                mem_we    = i_cmd_valid && (i_cmd.kind == lms_pkg::CMD_WRITE);
            end
            lms_pkg::SCAN_RUN: begin
                rd_en = rd_free;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lms_pkg::SCAN_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (rd_en) begin
                r_col <= col_last ? '0 : r_col + 1'b1;
                if (col_last) begin
                    r_row <= row_next;
                end
            end
            if (rd_en) begin
                r_rd_v <= 1'b1;
            end else if (move) begin
                r_rd_v <= 1'b0;
            end
            if (move) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Frame store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= i_cmd.color;
        end
        if (rd_en) begin
            r_rd_color <= mem[raddr];
            r_rd_hit   <= r_vld[raddr];
            r_rd_row   <= r_row;
            r_rd_col   <= r_col;
            r_rd_last  <= col_last;
        end
    end

    // Unwritten pixels read as no colour
    assign color = r_rd_hit ? r_rd_color : '0;

    // Output register
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.row_address  <= lms_pkg::FIELD_W'(r_rd_row);
            r_out.column_index <= lms_pkg::FIELD_W'(r_rd_col);
            r_out.red_bit      <= color[0];
            r_out.green_data   <= color[1];
            r_out.last_of_row  <= r_rd_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

[design/lms_checker.sv]
// Port-level checker for the row scanner, bound to the top level.
`include "led_matrix_row_scanner_defines.svh"

module lms_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lms_pkg::t_out o_out
);

    // A stalled result stays and holds its value
    `LMS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out), "stalled result changed")

    // The latch marker sits exactly on the final column
    `LMS_ASSERT_NOW(a_last_col, o_out_valid, o_out.last_of_row ==
        (o_out.column_index == lms_pkg::FIELD_W'(lms_pkg::MATRIX_COLUMNS - 1)),
        "last_of_row on wrong column")

    // Only columns inside the matrix are shifted out
    `LMS_ASSERT_NOW(a_col_range, o_out_valid,
        int'(o_out.column_index) < lms_pkg::MATRIX_COLUMNS, "column index out of range")

    // Reset empties the output register
    `LMS_ASSERT_ALWAYS_NEXT(a_rst_out, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind led_matrix_row_scanner lms_checker u_lms_checker (.*);

[tb/led_matrix_row_scanner_test.sv]
// Testbench for the LED matrix row scanner: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module led_matrix_row_scanner_test;

    // Pixel color codes
    localparam logic [lms_pkg::COLOR_W-1:0] COLOR_NONE   = 2'd0;
    localparam logic [lms_pkg::COLOR_W-1:0] COLOR_RED    = 2'd1;
    localparam logic [lms_pkg::COLOR_W-1:0] COLOR_GREEN  = 2'd2;
    localparam logic [lms_pkg::COLOR_W-1:0] COLOR_ORANGE = 2'd3;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 40;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_stall;
    lms_pkg::t_in  i_in        = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    lms_pkg::t_out o_out;

    // Predicted panel contents, scan position and pending shifted bits
    logic [lms_pkg::COLOR_W-1:0] panel_pixels [lms_pkg::STORE_DEPTH];
    logic [lms_pkg::ROW_W-1:0]   scan_row_now = '0;
    lms_pkg::t_out               pending_shift_bits [$];

    int error_count     = 0;
    int writes_sent     = 0;
    int scans_sent      = 0;
    int bits_checked    = 0;
    bit in_idle_on      = 1'b1;
    bit out_idle_on     = 1'b1;
    int holds_asked     = 0;
    int holds_taken     = 0;
    int hold_left       = 0;

    led_matrix_row_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Print one mismatch line (capped) and count it
    task automatic report_mismatch(string what);
        if (error_count < MAX_REPORTS) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    // Update the panel model for one accepted request and queue any scan bits
    task automatic predict_request(lms_pkg::t_in req);
        int            col;
        int            data_row;
        lms_pkg::t_out shift_bit;
        logic [1:0]    color;
        if (req.mode == lms_pkg::MODE_WRITE) begin
            if (req.column_x < lms_pkg::MATRIX_COLUMNS &&
                req.row_y < lms_pkg::MATRIX_ROWS) begin
                panel_pixels[req.row_y * lms_pkg::MATRIX_COLUMNS + req.column_x] =
                    req.pixel_color;
            end
            writes_sent++;
        end else begin
            // data comes from the row after the driven one, wrapping to row 0
            data_row = (scan_row_now + 1) % lms_pkg::MATRIX_ROWS;
            for (col = 0; col < lms_pkg::MATRIX_COLUMNS; col++) begin
                color = panel_pixels[data_row * lms_pkg::MATRIX_COLUMNS + col];
                shift_bit.row_address  = lms_pkg::FIELD_W'(scan_row_now);
                shift_bit.column_index = lms_pkg::FIELD_W'(col);
                shift_bit.red_bit      = color[0];
                shift_bit.green_data   = color[1];
                shift_bit.last_of_row  = (col == lms_pkg::MATRIX_COLUMNS - 1);
                pending_shift_bits.push_back(shift_bit);
            end
            scan_row_now = lms_pkg::ROW_W'((scan_row_now + 1) % lms_pkg::MATRIX_ROWS);
            scans_sent++;
        end
    endtask

    function automatic lms_pkg::t_in make_write(int x, int y,
                                                logic [lms_pkg::COLOR_W-1:0] color);
        lms_pkg::t_in req;
        req.mode        = lms_pkg::MODE_WRITE;
        req.column_x    = lms_pkg::FIELD_W'(x);
        req.row_y       = lms_pkg::FIELD_W'(y);
        req.pixel_color = color;
        return req;
    endfunction

    // Scan tick with junk in the fields it should ignore
    function automatic lms_pkg::t_in make_tick();
        lms_pkg::t_in req;
        req.mode        = lms_pkg::MODE_TICK;
        req.column_x    = lms_pkg::FIELD_W'($urandom);
        req.row_y       = lms_pkg::FIELD_W'($urandom);
        req.pixel_color = lms_pkg::COLOR_W'($urandom);
        return req;
    endfunction

    // Offer one request, hold it until accepted, then predict it
    task automatic send_request(lms_pkg::t_in req);
        if (in_idle_on) begin
            while ($urandom_range(99) < 28) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(req);
    endtask

    // Drop valid and wait until every predicted bit has been shifted out
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_shift_bits.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Compare one shifted bit with the oldest prediction
    task automatic check_shift_bit(lms_pkg::t_out got);
        lms_pkg::t_out want;
        if (pending_shift_bits.size() == 0) begin
            report_mismatch($sformatf("unexpected output %p", got));
        end else begin
            want = pending_shift_bits.pop_front();
            bits_checked++;
            if (got.row_address !== want.row_address)
                report_mismatch($sformatf("row_address %0d, predicted %0d",
                    got.row_address, want.row_address));
            if (got.column_index !== want.column_index)
                report_mismatch($sformatf("column_index %0d, predicted %0d",
                    got.column_index, want.column_index));
            if (got.red_bit !== want.red_bit)
                report_mismatch($sformatf("red_bit %b, predicted %b (row %0d col %0d)",
                    got.red_bit, want.red_bit, want.row_address, want.column_index));
            if (got.green_data !== want.green_data)
                report_mismatch($sformatf("green_data %b, predicted %b (row %0d col %0d)",
                    got.green_data, want.green_data, want.row_address, want.column_index));
            if (got.last_of_row !== want.last_of_row)
                report_mismatch($sformatf("last_of_row %b, predicted %b (col %0d)",
                    got.last_of_row, want.last_of_row, want.column_index));
        end
    endtask

    // Output side: check accepted bits, then choose next cycle's stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_shift_bit(o_out);
        end
        if (holds_asked != holds_taken) begin
            hold_left   = HOLD_CYCLES;
            holds_taken = holds_asked;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (out_idle_on) begin
            i_out_stall <= ($urandom_range(99) < 28);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Frame must read blank right after reset
    task automatic test_blank_after_reset();
        send_request(make_tick());
    endtask

    // Every color, overwrite, and both edge columns on one row
    task automatic test_pixel_colors();
        send_request(make_write(8, 2, COLOR_ORANGE));
        send_request(make_write(8, 2, COLOR_NONE));
        send_request(make_write(0, 2, COLOR_RED));
        send_request(make_write(7, 2, COLOR_GREEN));
        send_request(make_write(15, 2, COLOR_ORANGE));
        send_request(make_tick());
    endtask

    // Scan round to the last row, which shows row 0
    task automatic test_row_wrap();
        send_request(make_write(15, 15, COLOR_ORANGE));
        send_request(make_write(0, 15, COLOR_GREEN));
        send_request(make_write(0, 0, COLOR_GREEN));
        send_request(make_write(15, 0, COLOR_RED));
        do begin
            send_request(make_tick());
        end while (scan_row_now != 0);
    endtask

    // Mix of random writes and ticks
    task automatic test_random_mix(int count);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < 65)
                send_request(make_write($urandom_range(15), $urandom_range(15),
                    lms_pkg::COLOR_W'($urandom_range(3))));
            else
                send_request(make_tick());
        end
    endtask

    // Receiver holds off while ticks keep coming, so the input backs up
    task automatic test_output_hold_off();
        int n;
        in_idle_on = 1'b0;
        holds_asked++;
        for (n = 0; n < 6; n++) begin
            send_request(make_tick());
        end
        in_idle_on = 1'b1;
    endtask

    // Sender stops until everything is out, then carries on
    task automatic test_pause_for_drain();
        send_request(make_write($urandom_range(15),
            (scan_row_now + 1) % lms_pkg::MATRIX_ROWS, COLOR_ORANGE));
        send_request(make_tick());
        wait_for_drain();
        send_request(make_tick());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (panel_pixels[k]) panel_pixels[k] = COLOR_NONE;
        @(posedge i_clk);

        test_blank_after_reset();
        test_pixel_colors();
        test_row_wrap();
        test_random_mix(20);
        test_output_hold_off();
        test_pause_for_drain();

        // stretch with no idling on either side
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        test_random_mix(25);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        test_random_mix(20);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d pixel writes and %0d row scans, %0d shifted bits checked",
            writes_sent, scans_sent, bits_checked);
        $display("with a long output hold-off, a drain pause and runs with and without idling");
        if (error_count == 0 && pending_shift_bits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[led_matrix_row_scanner.f]
+incdir+design
design/lms_pkg.sv
design/lms_front.sv
design/lms_cmd_queue.sv
design/lms_scan_engine.sv
design/led_matrix_row_scanner.sv
design/lms_checker.sv
tb/led_matrix_row_scanner_test.sv
